// File: hdl/ndwd_pkg.sv
// Shared types and constants for the NDRange workgroup dispatcher.
package ndwd_pkg;

    localparam int WORD_W     = 32;
    localparam int MD_CNT_W   = $clog2(WORD_W);
    localparam int MAX_DIMS   = 3;
    localparam int IN_DATA_W  = 296;
    localparam int OUT_DATA_W = 128;
    localparam int IN_USER_W  = 2;
    localparam int IN_DIMS_W  = 2;
    localparam int GLOB_LSB   = IN_DIMS_W;
    localparam int LOC_LSB    = GLOB_LSB + MAX_DIMS * WORD_W;
    localparam int OFF_LSB    = LOC_LSB + MAX_DIMS * WORD_W;
    localparam int COUNT_W    = 4;
    localparam int INDEX_W    = 3;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_ADDR_W-1:0] CFG_CORE_COUNT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CORE_INDEX = 1'b1;

    typedef enum logic {
        MD_MUL,
        MD_DIV
    } md_op_t;

    typedef struct packed {
        logic   start;
        md_op_t op;
    } md_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV_N,
        ST_DIV_L,
        ST_MUL_OFF,
        ST_MUL_P,
        ST_MUL_S,
        ST_MUL_F,
        ST_DIV_S,
        ST_EMIT
    } state_t;

endpackage

// File: hdl/ndwd_muldiv.sv
// Shared iterative unit: 32-bit shift-add multiply (low half) or restoring divide.
module ndwd_muldiv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ndwd_pkg::md_req_t            req,
    input  logic [ndwd_pkg::WORD_W-1:0]  a,
    input  logic [ndwd_pkg::WORD_W-1:0]  b,
    output ndwd_pkg::md_rsp_t            rsp,
    output logic [ndwd_pkg::WORD_W-1:0]  result,
    output logic [ndwd_pkg::WORD_W-1:0]  remainder
);
    import ndwd_pkg::*;

    md_op_t              op_reg, op_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [MD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]   acc_reg, acc_next;
    logic [WORD_W-1:0]   sh_reg, sh_next;
    logic [WORD_W-1:0]   opd_reg, opd_next;
    logic [WORD_W:0]     trial;
    logic [WORD_W:0]     diff;

    assign trial = {acc_reg, sh_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, opd_reg};

    always_comb
    begin
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        opd_next  = opd_reg;
        if (req.start)
        begin
            op_next   = req.op;
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            sh_next   = (req.op == MD_DIV) ? a : b;
            opd_next  = (req.op == MD_DIV) ? b : a;
        end
        else if (busy_reg)
        begin
            if (op_reg == MD_DIV)
            begin
                if (!diff[WORD_W])
                begin
                    acc_next = diff[WORD_W-1:0];
                    sh_next  = {sh_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = trial[WORD_W-1:0];
                    sh_next  = {sh_reg[WORD_W-2:0], 1'b0};
                end
            end
            else
            begin
                if (sh_reg[0])
                begin
                    acc_next = acc_reg + opd_reg;
                end
                opd_next = {opd_reg[WORD_W-2:0], 1'b0};
                sh_next  = {1'b0, sh_reg[WORD_W-1:1]};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MD_CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= MD_MUL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            op_reg   <= op_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        opd_reg <= opd_next;
    end

    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;
    assign result    = (op_reg == MD_DIV) ? sh_reg : acc_reg;
    assign remainder = acc_reg;

endmodule

// File: hdl/ndrange_workgroup_dispatcher.sv
// Top level: launch setup sequencer, workgroup counter and stream ports.
//
// Input stream s_*: one request per workgroup. tuser[0] = 0 starts a new launch
// with the sizes in tdata, tuser[0] = 1 asks for the next workgroup. Output
// stream m_*: exactly one result per request (start ids and index in tdata,
// final workgroup of this core on tlast, no_work on tuser).
// Configuration: cfg_wen/cfg_addr/cfg_wdata write core_count (0) and
// core_index (1); write them only while the block is idle.
// Timing: a next request goes from IDLE through EMIT to the output register. A start request
// runs LOAD and then a number of operations on the shared multiply/divide unit:
// up to two divides per dimension tried for the split, one multiply
// for the core offset, 2*DIMENSIONS multiplies for the size products, and a
// multiply and divide for the base index. s_tready is high only in
// IDLE; one request is in flight at a time.
// Reset clears the configuration to one core, index zero, with no launch active.
// A stalled receiver holds the result in the output register; a following
// request is accepted, but its result waits until the register is free.
module ndrange_workgroup_dispatcher #(
    parameter int DIMENSIONS = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wen,
    input  logic [ndwd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ndwd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // dimension_count, global_size_x/y/z, local_size_x/y/z, offset_x/y/z, zero pad
    input  logic [ndwd_pkg::IN_DATA_W-1:0]     s_tdata,
    // mode, debug_launch
    input  logic [ndwd_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // start_x, start_y, start_z, workgroup_index
    output logic [ndwd_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    // no_work
    output logic [0:0]                         m_tuser
);
    import ndwd_pkg::*;

    localparam int DW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam logic [DW-1:0] D_LAST   = DW'(DIMENSIONS - 1);
    localparam logic [1:0]    DIMS_MAX = 2'(DIMENSIONS);

    state_t               state_reg, state_next;
    logic                 issued_reg, issued_next;
    logic [DW-1:0]        d_reg, d_next;
    logic                 running_reg, running_next;
    logic                 debug_reg, debug_next;
    logic [1:0]           active_dims_reg, active_dims_next;
    logic [COUNT_W-1:0]   core_count_reg;
    logic [INDEX_W-1:0]   core_index_reg;
    logic [WORD_W-1:0]    next_index_reg, next_index_next;
    logic [WORD_W-1:0]    share_reg, share_next;
    logic [WORD_W-1:0]    p_reg, p_next;
    logic [WORD_W-1:0]    s_reg, s_next;
    logic [WORD_W-1:0]    limit_reg [DIMENSIONS];
    logic [WORD_W-1:0]    limit_next [DIMENSIONS];
    logic [WORD_W-1:0]    step_reg [DIMENSIONS];
    logic [WORD_W-1:0]    step_next [DIMENSIONS];
    logic [WORD_W-1:0]    off_reg [DIMENSIONS];
    logic [WORD_W-1:0]    off_next [DIMENSIONS];
    logic [WORD_W-1:0]    pos_reg [DIMENSIONS];
    logic [WORD_W-1:0]    pos_next [DIMENSIONS];
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_nowork_reg, m_nowork_next;

    logic [WORD_W-1:0]    in_glob [MAX_DIMS];
    logic [WORD_W-1:0]    in_loc [MAX_DIMS];
    logic [WORD_W-1:0]    in_off [MAX_DIMS];
    logic [IN_DIMS_W-1:0] in_dims;
    logic [1:0]           dims_sat;
    logic [COUNT_W-1:0]   n_cores;
    logic                 multi;
    logic                 master;
    logic [WORD_W-1:0]    start_w [MAX_DIMS];
    logic [WORD_W-1:0]    pos_adv [DIMENSIONS];
    logic                 step_done;
    logic                 carry;
    logic                 arith;
    logic                 go_prod;
    logic                 no_run;
    logic                 no_split;

    md_req_t              md_req;
    md_rsp_t              md_rsp;
    logic [WORD_W-1:0]    md_a;
    logic [WORD_W-1:0]    md_b;
    logic [WORD_W-1:0]    md_result;
    logic [WORD_W-1:0]    md_rem;

    ndwd_muldiv u_muldiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (md_req),
        .a         (md_a),
        .b         (md_b),
        .rsp       (md_rsp),
        .result    (md_result),
        .remainder (md_rem)
    );

    always_comb
    begin
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            in_glob[k] = s_tdata[GLOB_LSB + WORD_W * k +: WORD_W];
            in_loc[k]  = s_tdata[LOC_LSB + WORD_W * k +: WORD_W];
            in_off[k]  = s_tdata[OFF_LSB + WORD_W * k +: WORD_W];
        end
    end

    assign in_dims  = s_tdata[IN_DIMS_W-1:0];
    assign dims_sat = (in_dims == 2'd0) ? 2'd1 : ((in_dims > DIMS_MAX) ? DIMS_MAX : in_dims);
    assign n_cores  = (core_count_reg == '0) ? COUNT_W'(1) : core_count_reg;
    assign multi    = (n_cores != COUNT_W'(1));
    assign master   = (core_index_reg == '0) || !multi;

    genvar g;
    for (g = 0; g < MAX_DIMS; g++)
    begin : g_start
        if (g < DIMENSIONS)
        begin : g_on
            assign start_w[g] = off_reg[g] + pos_reg[g];
        end
        else
        begin : g_off
            assign start_w[g] = '0;
        end
    end

    // mixed-radix advance over the active dimensions
    always_comb
    begin
        carry     = 1'b1;
        step_done = 1'b1;
        for (int i = 0; i < DIMENSIONS; i++)
        begin
            pos_adv[i] = pos_reg[i];
            if (carry && (2'(i) < active_dims_reg))
            begin
                if ((pos_reg[i] + step_reg[i]) < limit_reg[i])
                begin
                    pos_adv[i] = pos_reg[i] + step_reg[i];
                    step_done  = 1'b0;
                    carry      = 1'b0;
                end
                else
                begin
                    pos_adv[i] = '0;
                end
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        issued_next      = issued_reg;
        d_next           = d_reg;
        running_next     = running_reg;
        debug_next       = debug_reg;
        active_dims_next = active_dims_reg;
        next_index_next  = next_index_reg;
        share_next       = share_reg;
        p_next           = p_reg;
        s_next           = s_reg;
        limit_next       = limit_reg;
        step_next        = step_reg;
        off_next         = off_reg;
        pos_next         = pos_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        m_last_next      = m_last_reg;
        m_nowork_next    = m_nowork_reg;
        md_req.start     = 1'b0;
        md_req.op        = MD_MUL;
        md_a             = '0;
        md_b             = '0;
        arith            = 1'b0;
        go_prod          = 1'b0;
        no_run           = 1'b0;
        no_split         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (!s_tuser[0])
                    begin
                        for (int k = 0; k < DIMENSIONS; k++)
                        begin
                            limit_next[k] = in_glob[k];
                            step_next[k]  = in_loc[k];
                            off_next[k]   = in_off[k];
                            pos_next[k]   = '0;
                        end
                        active_dims_next = dims_sat;
                        debug_next       = s_tuser[1];
                        running_next     = 1'b0;
                        state_next       = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_LOAD:
            begin
                if (debug_reg)
                begin
                    if (master)
                    begin
                        go_prod = 1'b1;
                    end
                    else
                    begin
                        no_run = 1'b1;
                    end
                end
                else if (!multi)
                begin
                    go_prod = 1'b1;
                end
                else
                begin
                    d_next     = DW'(active_dims_reg - 2'd1);
                    state_next = ST_DIV_N;
                end
            end
            ST_DIV_N:
            begin
                arith     = 1'b1;
                md_req.op = MD_DIV;
                md_a      = limit_reg[d_reg];
                md_b      = WORD_W'(n_cores);
                if (md_rsp.done)
                begin
                    if ((md_rem == '0) && (step_reg[d_reg] != '0))
                    begin
                        share_next = md_result;
                        state_next = ST_DIV_L;
                    end
                    else
                    begin
                        no_split = 1'b1;
                    end
                end
            end
            ST_DIV_L:
            begin
                arith     = 1'b1;
                md_req.op = MD_DIV;
                md_a      = share_reg;
                md_b      = step_reg[d_reg];
                if (md_rsp.done)
                begin
                    if (md_rem == '0)
                    begin
                        limit_next[d_reg] = share_reg;
                        state_next        = ST_MUL_OFF;
                    end
                    else
                    begin
                        no_split = 1'b1;
                    end
                end
            end
            ST_MUL_OFF:
            begin
                arith     = 1'b1;
                md_req.op = MD_MUL;
                md_a      = share_reg;
                md_b      = WORD_W'(core_index_reg);
                if (md_rsp.done)
                begin
                    off_next[d_reg] = off_reg[d_reg] + md_result;
                    go_prod         = 1'b1;
                end
            end
            ST_MUL_P:
            begin
                arith     = 1'b1;
                md_req.op = MD_MUL;
                md_a      = p_reg;
                md_b      = limit_reg[d_reg];
                if (md_rsp.done)
                begin
                    p_next     = md_result;
                    state_next = ST_MUL_S;
                end
            end
            ST_MUL_S:
            begin
                arith     = 1'b1;
                md_req.op = MD_MUL;
                md_a      = s_reg;
                md_b      = step_reg[d_reg];
                if (md_rsp.done)
                begin
                    s_next = md_result;
                    if (d_reg == D_LAST)
                    begin
                        if ((md_result == '0) || !multi || (core_index_reg == '0))
                        begin
                            next_index_next = '0;
                            running_next    = 1'b1;
                            state_next      = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_MUL_F;
                        end
                    end
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        state_next = ST_MUL_P;
                    end
                end
            end
            ST_MUL_F:
            begin
                arith     = 1'b1;
                md_req.op = MD_MUL;
                md_a      = p_reg;
                md_b      = WORD_W'(core_index_reg);
                if (md_rsp.done)
                begin
                    share_next = md_result;
                    state_next = ST_DIV_S;
                end
            end
            ST_DIV_S:
            begin
                arith     = 1'b1;
                md_req.op = MD_DIV;
                md_a      = share_reg;
                md_b      = s_reg;
                if (md_rsp.done)
                begin
                    next_index_next = md_result;
                    running_next    = 1'b1;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    if (running_reg)
                    begin
                        m_data_next     = {next_index_reg, start_w[2], start_w[1], start_w[0]};
                        m_last_next     = step_done;
                        m_nowork_next   = 1'b0;
                        next_index_next = next_index_reg + 1'b1;
                        pos_next        = pos_adv;
                        if (step_done)
                        begin
                            running_next = 1'b0;
                        end
                    end
                    else
                    begin
                        m_data_next   = '0;
                        m_last_next   = 1'b0;
                        m_nowork_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (arith)
        begin
            md_req.start = !issued_reg;
            issued_next  = !md_rsp.done;
        end

        if (no_split)
        begin
            if (d_reg == '0)
            begin
                if (master)
                begin
                    go_prod = 1'b1;
                end
                else
                begin
                    no_run = 1'b1;
                end
            end
            else
            begin
                d_next     = d_reg - 1'b1;
                state_next = ST_DIV_N;
            end
        end

        if (go_prod)
        begin
            d_next     = '0;
            p_next     = WORD_W'(1);
            s_next     = WORD_W'(1);
            state_next = ST_MUL_P;
        end

        if (no_run)
        begin
            running_next = 1'b0;
            state_next   = ST_EMIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            issued_reg      <= 1'b0;
            d_reg           <= '0;
            running_reg     <= 1'b0;
            debug_reg       <= 1'b0;
            active_dims_reg <= 2'd1;
            next_index_reg  <= '0;
            core_count_reg  <= COUNT_W'(1);
            core_index_reg  <= '0;
            m_valid_reg     <= 1'b0;
            for (int k = 0; k < DIMENSIONS; k++)
            begin
                pos_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            issued_reg      <= issued_next;
            d_reg           <= d_next;
            running_reg     <= running_next;
            debug_reg       <= debug_next;
            active_dims_reg <= active_dims_next;
            next_index_reg  <= next_index_next;
            m_valid_reg     <= m_valid_next;
            pos_reg         <= pos_next;
            if (cfg_wen)
            begin
                case (cfg_addr)
                    CFG_CORE_COUNT: core_count_reg <= cfg_wdata;
                    CFG_CORE_INDEX: core_index_reg <= cfg_wdata[INDEX_W-1:0];
                    default:        core_index_reg <= core_index_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        share_reg    <= share_next;
        p_reg        <= p_next;
        s_reg        <= s_next;
        limit_reg    <= limit_next;
        step_reg     <= step_next;
        off_reg      <= off_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
        m_nowork_reg <= m_nowork_next;
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_nowork_reg;

`ifndef SYNTHESIS
    a_nowork_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> ((m_tdata == '0) && !m_tlast))
        else $error("no_work result carries data");

    a_next_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0]) |=> (state_reg == ST_EMIT))
        else $error("next request did not go straight to emit");

    a_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        md_req.start |-> !md_rsp.busy)
        else $error("shared unit started while busy");

    a_setup_runs_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (md_rsp.busy && !md_rsp.done) |-> (issued_reg && !s_tready))
        else $error("shared unit busy outside a launch setup");
`endif

endmodule

// File: test/workgroup_checker.sv
// Workgroup checker: predicts each dispatcher result and compares it with the output stream.
module workgroup_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [ndwd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ndwd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // dimension_count, global_size_x/y/z, local_size_x/y/z, offset_x/y/z, zero pad
    input  logic [ndwd_pkg::IN_DATA_W-1:0]  s_tdata,
    // mode, debug_launch
    input  logic [ndwd_pkg::IN_USER_W-1:0]  s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // start_x, start_y, start_z, workgroup_index
    input  logic [ndwd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            m_tlast,
    // no_work
    input  logic [0:0]                      m_tuser,
    output int                              errors,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ndwd_pkg::*;

    typedef struct packed {
        logic [MAX_DIMS-1:0][WORD_W-1:0] start;
        logic [WORD_W-1:0]               index;
        logic                            last;
        logic                            no_work;
    } workgroup_t;

    logic [WORD_W-1:0]  wg_pos    [MAX_DIMS];
    logic [WORD_W-1:0]  wg_span   [MAX_DIMS];
    logic [WORD_W-1:0]  wg_origin [MAX_DIMS];
    logic [WORD_W-1:0]  wg_stride [MAX_DIMS];
    logic [1:0]         live_dims;
    logic [WORD_W-1:0]  next_wg;
    bit                 launch_live;
    logic [COUNT_W-1:0] cores;
    logic [INDEX_W-1:0] my_core;

    workgroup_t expected_workgroups[$];
    int         fail_count = 0;

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        fail_count++;
        if (fail_count <= 50)
            $display("%0t ns workgroup mismatch on %s: got %h, want %h",
                     $time, what, got, want);
    endtask

    // Loads a launch on a start request, then emits and advances one workgroup.
    task automatic dispatch_request(input logic [IN_USER_W-1:0] user,
                                    input logic [IN_DATA_W-1:0] data,
                                    output workgroup_t wg);
        logic [WORD_W-1:0] n, f, ci, p, s, fp, share;
        logic [1:0]        dims;
        bit                master, runs, split, done;
        if (!user[0]) begin
            dims = data[IN_DIMS_W-1:0];
            if (dims == 0)
                dims = 1;
            live_dims = dims;
            n  = (cores == 0) ? 32'd1 : WORD_W'(cores);
            ci = WORD_W'(my_core);
            master = (my_core == 0) || (n == 1);
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                wg_span[d]   = data[GLOB_LSB + d*WORD_W +: WORD_W];
                wg_stride[d] = data[LOC_LSB + d*WORD_W +: WORD_W];
                wg_origin[d] = data[OFF_LSB + d*WORD_W +: WORD_W];
                wg_pos[d]    = '0;
            end
            if (user[1])
                runs = master;
            else if (n == 1)
                runs = 1'b1;
            else
            begin
                runs  = master;
                split = 1'b0;
                for (int d = int'(dims) - 1; d >= 0; d--)
                begin
                    if (!split && wg_span[d] % n == 0 && wg_stride[d] != 0
                        && (wg_span[d] / n) % wg_stride[d] == 0)
                    begin
                        share        = wg_span[d] / n;
                        wg_span[d]   = share;
                        wg_origin[d] = wg_origin[d] + ci * share;
                        split        = 1'b1;
                        runs         = 1'b1;
                    end
                end
            end
            if (runs)
            begin
                f = (n > 1) ? ci : '0;
                p = 1;
                s = 1;
                for (int d = 0; d < MAX_DIMS; d++)
                begin
                    p = p * wg_span[d];
                    s = s * wg_stride[d];
                end
                fp = f * p;
                next_wg = (s != 0) ? fp / s : '0;
            end
            launch_live = runs;
        end

        wg = '0;
        if (!launch_live) begin
            wg.no_work = 1'b1;
            return;
        end
        for (int d = 0; d < MAX_DIMS; d++)
            wg.start[d] = wg_origin[d] + wg_pos[d];
        wg.index = next_wg;
        next_wg  = next_wg + 1;

        // mixed-radix step, lowest dimension first
        done = 1'b1;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            if (done && i < int'(live_dims))
            begin
                wg_pos[i] = wg_pos[i] + wg_stride[i];
                if (wg_pos[i] < wg_span[i])
                    done = 1'b0;
                else
                    wg_pos[i] = '0;
            end
        end
        if (done)
            launch_live = 1'b0;
        wg.last = done;
    endtask

    task automatic check_workgroup(input workgroup_t want);
        for (int d = 0; d < MAX_DIMS; d++)
            if (m_tdata[d*WORD_W +: WORD_W] !== want.start[d])
                report_mismatch($sformatf("start[%0d]", d), m_tdata[d*WORD_W +: WORD_W],
                                want.start[d]);
        if (m_tdata[MAX_DIMS*WORD_W +: WORD_W] !== want.index)
            report_mismatch("workgroup_index", m_tdata[MAX_DIMS*WORD_W +: WORD_W], want.index);
        if (m_tlast !== want.last)
            report_mismatch("last", WORD_W'(m_tlast), WORD_W'(want.last));
        if (m_tuser[0] !== want.no_work)
            report_mismatch("no_work", WORD_W'(m_tuser[0]), WORD_W'(want.no_work));
    endtask

    always @(posedge clk)
    begin : monitor
        workgroup_t wg;
        if (!rst_n)
        begin
            cores       = 4'd1;
            my_core     = '0;
            live_dims   = 2'd1;
            next_wg     = '0;
            launch_live = 1'b0;
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                wg_pos[d]    = '0;
                wg_span[d]   = '0;
                wg_origin[d] = '0;
                wg_stride[d] = '0;
            end
            expected_workgroups.delete();
        end
        else
        begin
            if (cfg_wen)
            begin
                if (cfg_addr == CFG_CORE_COUNT)
                    cores = cfg_wdata;
                else if (cfg_addr == CFG_CORE_INDEX)
                    my_core = cfg_wdata[INDEX_W-1:0];
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_workgroups.size() == 0)
                    report_mismatch("result with no request", m_tdata[WORD_W-1:0], '0);
                else
                    check_workgroup(expected_workgroups.pop_front());
            end
            if (s_tvalid && s_tready)
            begin
                dispatch_request(s_tuser, s_tdata, wg);
                expected_workgroups.push_back(wg);
            end
        end
        errors  <= fail_count;
        pending <= expected_workgroups.size();
    end

endmodule

// File: test/tb_top.sv
// Testbench top: drives launch and next requests and core settings, and gives the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ndwd_pkg::*;

    // count and index per random phase, phase 0 in the lowest nibble
    localparam logic [39:0] PHASE_COUNTS  = {4'd15, 4'd1, 4'd6, 4'd8, 4'd0,
                                             4'd3, 4'd4, 4'd2, 4'd8, 4'd8};
    localparam logic [39:0] PHASE_INDEXES = {4'd15, 4'd4, 4'd7, 4'd3, 4'd5,
                                             4'd2, 4'd0, 4'd1, 4'd7, 4'd0};
    localparam int PHASES          = 10;
    localparam int PHASE_REQUESTS  = 143;
    localparam int HOLD_OFF_CYCLES = 600;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic [0:0]            m_tuser;

    int fail_total;
    int queued;

    bit gaps_on      = 1'b1;
    bit hold_off_req = 1'b0;
    int items_sent   = 0;
    int cur_cores    = 1;

    logic [WORD_W-1:0] glob [MAX_DIMS];
    logic [WORD_W-1:0] loc  [MAX_DIMS];
    logic [WORD_W-1:0] offs [MAX_DIMS];

    ndrange_workgroup_dispatcher #(
        .DIMENSIONS (MAX_DIMS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    workgroup_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .errors    (fail_total),
        .pending   (queued)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // result receiver: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
                m_tready <= (gaps_on && $urandom_range(99) < 32) ? 1'b0 : 1'b1;
        end
    end

    function automatic logic [IN_DATA_W-1:0] random_bus();
        logic [IN_DATA_W-1:0] v;
        v = '0;
        repeat ((IN_DATA_W + 31) / 32)
            v = (v << 32) | IN_DATA_W'($urandom);
        return v;
    endfunction

    task automatic offer(input logic [IN_USER_W-1:0] user, input logic [IN_DATA_W-1:0] data);
        while (gaps_on && $urandom_range(99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= user;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic launch(input bit debug, input logic [1:0] dims);
        logic [IN_DATA_W-1:0] data;
        data = '0;
        data[IN_DIMS_W-1:0] = dims;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            data[GLOB_LSB + d*WORD_W +: WORD_W] = glob[d];
            data[LOC_LSB + d*WORD_W +: WORD_W]  = loc[d];
            data[OFF_LSB + d*WORD_W +: WORD_W]  = offs[d];
        end
        offer({debug, 1'b0}, data);
    endtask

    // next request; the data bus and debug bit are don't-care here
    task automatic next_req();
        offer({1'($urandom), 1'b1}, random_bus());
    endtask

    task automatic shape(input logic [WORD_W-1:0] gx, gy, gz, lx, ly, lz);
        glob[0] = gx;
        glob[1] = gy;
        glob[2] = gz;
        loc[0]  = lx;
        loc[1]  = ly;
        loc[2]  = lz;
        for (int d = 0; d < MAX_DIMS; d++)
            offs[d] = $urandom;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (queued != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_cores(input logic [CFG_DATA_W-1:0] count,
                             input logic [CFG_DATA_W-1:0] index);
        settle();
        cfg_wen   <= 1'b1;
        cfg_addr  <= CFG_CORE_COUNT;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_addr  <= CFG_CORE_INDEX;
        cfg_wdata <= index;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        cur_cores = int'(count);
    endtask

    // mostly splittable sizes, small enough that launches finish
    task automatic random_launch();
        int unsigned n;
        int unsigned split;
        n = (cur_cores == 0) ? 1 : cur_cores;
        split = $urandom_range(2);
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            loc[d]  = $urandom_range(1, 3);
            glob[d] = loc[d] * $urandom_range(1, 2);
            offs[d] = $urandom;
        end
        glob[split] = loc[split] * n * $urandom_range(1, 2);
        case ($urandom_range(9))
            0: glob[split] = glob[split] + 1;
            1: glob[$urandom_range(2)] = '0;
            2: loc[$urandom_range(2)] = '0;
            default: ;
        endcase
        launch($urandom_range(9) == 0, 2'($urandom_range(3)));
    endtask

    initial
    begin
        int unsigned goal;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single core, reset settings
        next_req();                                         // no launch active
        shape(0, 0, 0, 1, 1, 1);
        offs[0] = '1;
        launch(1'b0, 2'd0);                                 // zero dims, zero size
        next_req();
        shape(4, 2, 2, 2, 1, 2);
        offs = '{default: '1};
        launch(1'b1, 2'd3);                                 // debug on master
        repeat (3) next_req();
        shape(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'h8000_0001, 32'hFFFF_FFFF, 0);
        launch(1'b0, 2'd2);                                 // position wraps
        repeat (2) next_req();
        shape(3, 1, 1, 0, 1, 1);
        launch(1'b0, 2'd1);                                 // restart, zero step
        repeat (2) next_req();
        shape(32'h2_0000, 32'h2_0000, 32'h2_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000);
        launch(1'b0, 2'd3);

        // four cores, this one last
        set_cores(4, 3);
        shape(8, 6, 16, 1, 3, 2);
        launch(1'b0, 2'd3);                                 // z splits
        next_req();
        launch(1'b1, 2'd3);                                 // debug, not master
        shape(7, 7, 7, 1, 1, 1);
        launch(1'b0, 2'd3);                                 // nothing splits
        next_req();
        shape(32'h4_0000, 32'h4_0000, 32'h4_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000);
        launch(1'b0, 2'd3);                                 // size product wraps
        shape(8, 8, 8, 0, 1, 1);
        launch(1'b0, 2'd1);                                 // zero local size

        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_cores(PHASE_COUNTS[ph*4 +: 4], PHASE_INDEXES[ph*4 +: 4]);
            gaps_on = (ph != 0);
            if (ph == 3)
                hold_off_req = 1'b1;
            goal = items_sent + PHASE_REQUESTS;
            while (items_sent < goal)
            begin
                if ($urandom_range(99) < 85)
                begin
                    random_launch();
                    repeat ($urandom_range(10)) next_req();
                end
                else
                begin
                    offer(2'($urandom), random_bus());
                    repeat ($urandom_range(3)) next_req();
                end
            end
        end

        settle();
        repeat (16) @(posedge clk);
        if (fail_total == 0 && queued == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: ndrange_workgroup_dispatcher.f
hdl/ndwd_pkg.sv
hdl/ndwd_muldiv.sv
hdl/ndrange_workgroup_dispatcher.sv
test/workgroup_checker.sv
test/tb_top.sv
